### src/spi_port_transaction_master_defines.svh
// Assertion macros shared by the SPI port transaction master.
`ifndef SPI_PORT_TRANSACTION_MASTER_DEFINES_SVH
`define SPI_PORT_TRANSACTION_MASTER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SPTM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SPTM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/sptm_pkg.sv
// Types and constants of the SPI port transaction master.
package sptm_pkg;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_CMD   = 5'b00010,
		PH_WDATA = 5'b00100,
		PH_POLL  = 5'b01000,
		PH_RDATA = 5'b10000
	} phase_t;

	localparam logic [1:0] FUNC_START_READ  = 2'd0;
	localparam logic [1:0] FUNC_START_WRITE = 2'd1;
	localparam logic [1:0] FUNC_SLOT        = 2'd2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
	localparam logic [1:0] STATUS_BAD_ACK = 2'd2;

	localparam logic [7:0] WRITE_FLAG  = 8'h80;
	localparam logic [7:0] PORT_MASK   = 8'h7f;
	localparam logic [7:0] POLL_BYTE   = 8'hff;
	localparam logic [7:0] ACK_READ    = 8'hc0;
	localparam logic [7:0] ACK_WRITE   = 8'h80;
	localparam logic [7:0] RETRY_RESET = 8'd100;

	// One result word as it is computed from one input word.
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       select_active;
		logic [2:0] select_index;
		logic       rd_valid;
		logic [7:0] rd_byte;
		logic       done_res;
		logic [1:0] status;
	} result_t;

endpackage

### src/spi_port_transaction_master.sv
// SPI port transaction master: command, write data, status poll and read data sequencing.
// Each input word is one start request or one completed SPI byte slot, and it yields exactly
// one result word. A word is registered on acceptance; once the result register is free, the
// transaction state is updated and the result is registered. One word can be accepted every
// cycle; input words are held off only while the result register is full and stalled.
// The retry limit register is written through its own port with ready always high.
`include "spi_port_transaction_master_defines.svh"

module spi_port_transaction_master #(
	parameter int NUM_TARGETS = 8
) (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,

	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] func,
	input  logic [6:0] port,
	input  logic [2:0] target,
	input  logic [7:0] length,
	input  logic [7:0] wdata,
	input  logic [7:0] rx_byte,

	output logic       res_valid,
	input  logic       res_stall,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       select_active,
	output logic [2:0] select_index,
	output logic       rd_valid,
	output logic [7:0] rd_byte,
	output logic       done_res,
	output logic [1:0] status
);

	// Targets beyond this count are refused; the compare is wide enough for the largest count.
	localparam logic [6:0] NumTargetsW = 7'(NUM_TARGETS);

	logic [7:0] retry_limit_q;

	logic       valid_s1;
	logic [1:0] func_s1;
	logic [6:0] port_s1;
	logic [2:0] target_s1;
	logic [7:0] length_s1;
	logic [7:0] wdata_s1;
	logic [7:0] rx_s1;

	sptm_pkg::phase_t phase_q, phase_d;
	logic       is_write_q, is_write_d;
	logic [2:0] cur_target_q, cur_target_d;
	logic [7:0] bytes_left_q, bytes_left_d;
	logic [7:0] poll_count_q, poll_count_d;

	logic       res_valid_q;
	sptm_pkg::result_t res_q, res_d;

	logic res_free;
	logic advance;
	logic accept;

	logic [7:0] poll_next;
	logic [7:0] ack_byte;
	logic [7:0] left_dec;

	assign cfg_ready  = 1'b1;
	assign res_free   = !res_valid_q || !res_stall;
	assign advance    = valid_s1 && res_free;
	assign item_stall = valid_s1 && !res_free;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= sptm_pkg::RETRY_RESET;
		end else if (cfg_valid) begin
			retry_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= func;
			port_s1   <= port;
			target_s1 <= target;
			length_s1 <= length;
			wdata_s1  <= wdata;
			rx_s1     <= rx_byte;
		end
	end

	assign poll_next = poll_count_q + 8'd1;
	assign left_dec  = bytes_left_q - 8'd1;
	assign ack_byte  = is_write_q ? sptm_pkg::ACK_WRITE : sptm_pkg::ACK_READ;

	always_comb begin
		phase_d      = phase_q;
		is_write_d   = is_write_q;
		cur_target_d = cur_target_q;
		bytes_left_d = bytes_left_q;
		poll_count_d = poll_count_q;
		res_d        = '0;

		if (func_s1 == sptm_pkg::FUNC_START_READ || func_s1 == sptm_pkg::FUNC_START_WRITE) begin
			if (phase_q == sptm_pkg::PH_IDLE && {4'b0000, target_s1} < NumTargetsW) begin
				is_write_d     = func_s1[0];
				cur_target_d   = target_s1;
				bytes_left_d   = length_s1;
				poll_count_d   = 8'd0;
				phase_d        = sptm_pkg::PH_CMD;
				res_d.tx_valid = 1'b1;
				res_d.tx_byte  = func_s1[0] ? ({1'b0, port_s1} | sptm_pkg::WRITE_FLAG)
					: ({1'b0, port_s1} & sptm_pkg::PORT_MASK);
			end
		end else if (func_s1 == sptm_pkg::FUNC_SLOT) begin
			case (phase_q)
				sptm_pkg::PH_CMD, sptm_pkg::PH_WDATA: begin
					res_d.tx_valid = 1'b1;
					if (is_write_q && bytes_left_q != 8'd0) begin
						bytes_left_d  = left_dec;
						phase_d       = sptm_pkg::PH_WDATA;
						res_d.tx_byte = wdata_s1;
					end else begin
						poll_count_d  = 8'd0;
						phase_d       = sptm_pkg::PH_POLL;
						res_d.tx_byte = sptm_pkg::POLL_BYTE;
					end
				end
				sptm_pkg::PH_POLL: begin
					// The retry limit is checked before the status byte, so it wins a tie.
					poll_count_d = poll_next;
					if (poll_next == retry_limit_q) begin
						res_d.done_res = 1'b1;
						res_d.status   = sptm_pkg::STATUS_TIMEOUT;
						phase_d        = sptm_pkg::PH_IDLE;
					end else if (rx_s1 == sptm_pkg::POLL_BYTE) begin
						res_d.tx_valid = 1'b1;
						res_d.tx_byte  = sptm_pkg::POLL_BYTE;
					end else if (rx_s1 != ack_byte) begin
						res_d.done_res = 1'b1;
						res_d.status   = sptm_pkg::STATUS_BAD_ACK;
						phase_d        = sptm_pkg::PH_IDLE;
					end else if (!is_write_q && bytes_left_q != 8'd0) begin
						phase_d        = sptm_pkg::PH_RDATA;
						res_d.tx_valid = 1'b1;
						res_d.tx_byte  = sptm_pkg::POLL_BYTE;
					end else begin
						res_d.done_res = 1'b1;
						res_d.status   = sptm_pkg::STATUS_OK;
						phase_d        = sptm_pkg::PH_IDLE;
					end
				end
				sptm_pkg::PH_RDATA: begin
					res_d.rd_valid = 1'b1;
					res_d.rd_byte  = rx_s1;
					bytes_left_d   = left_dec;
					if (left_dec != 8'd0) begin
						res_d.tx_valid = 1'b1;
						res_d.tx_byte  = sptm_pkg::POLL_BYTE;
					end else begin
						res_d.done_res = 1'b1;
						res_d.status   = sptm_pkg::STATUS_OK;
						phase_d        = sptm_pkg::PH_IDLE;
					end
				end
				default: begin
				end
			endcase
		end

		res_d.select_active = (phase_d != sptm_pkg::PH_IDLE);
		res_d.select_index  = cur_target_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= sptm_pkg::PH_IDLE;
			is_write_q   <= 1'b0;
			cur_target_q <= 3'd0;
			bytes_left_q <= 8'd0;
			poll_count_q <= 8'd0;
		end else if (advance) begin
			phase_q      <= phase_d;
			is_write_q   <= is_write_d;
			cur_target_q <= cur_target_d;
			bytes_left_q <= bytes_left_d;
			poll_count_q <= poll_count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign res_valid     = res_valid_q;
	assign tx_valid      = res_q.tx_valid;
	assign tx_byte       = res_q.tx_byte;
	assign select_active = res_q.select_active;
	assign select_index  = res_q.select_index;
	assign rd_valid      = res_q.rd_valid;
	assign rd_byte       = res_q.rd_byte;
	assign done_res      = res_q.done_res;
	assign status        = res_q.status;

	`SPTM_ASSERT_NOW(a_done_releases_select, res_valid_q && res_q.done_res, !res_q.select_active, "select still held on the word that ends the transaction")
	`SPTM_ASSERT_NOW(a_read_byte_context, res_valid_q && res_q.rd_valid, res_q.tx_valid || res_q.done_res, "read data word neither continues nor ends the transaction")
	`SPTM_ASSERT_NEXT(a_advance_updates_result, advance, res_valid_q && res_q.select_active == (phase_q != sptm_pkg::PH_IDLE), "result register does not match the new transaction state")

endmodule
